@@ rtl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/clnws_pkg.sv @@
package clnws_pkg;

  typedef enum logic [1:0] {
    ACT_INIT = 2'd0,
    ACT_CMD  = 2'd1,
    ACT_CHAR = 2'd2,
    ACT_GOTO = 2'd3
  } action_e;

  localparam logic [1:0] REG_LINE0_BASE = 2'd0;
  localparam logic [1:0] REG_LINE1_BASE = 2'd1;
  localparam logic [1:0] REG_LINE2_BASE = 2'd2;
  localparam logic [1:0] REG_LINE3_BASE = 2'd3;

  localparam logic [6:0] LINE0_RESET = 7'd0;
  localparam logic [6:0] LINE1_RESET = 7'd64;
  localparam logic [6:0] LINE2_RESET = 7'd20;
  localparam logic [6:0] LINE3_RESET = 7'd84;

  localparam logic [7:0] CMD_FUNCTION_SET = 8'h28;
  localparam logic [7:0] CMD_DISPLAY_ON   = 8'h0C;
  localparam logic [7:0] CMD_SET_ADDRESS  = 8'h80;

  localparam logic [3:0] NIB_WAKE  = 4'h3;
  localparam logic [3:0] NIB_4BIT  = 4'h2;
  localparam logic [3:0] HOLD_LONG = 4'd15;
  localparam logic [3:0] HOLD_SHORT = 4'd1;

  localparam logic [3:0] INIT_LAST_IDX = 4'd14;

  typedef struct packed {
    logic       is_init;
    logic [7:0] byte_val;
    logic       rs;
  } desc_t;

  typedef struct packed {
    logic [3:0] nibble;
    logic       reg_select;
    logic       enable;
    logic [3:0] hold_ms;
    logic       last;
  } event_t;

  function automatic event_t lcd_event(desc_t d, logic [3:0] idx);
    event_t     ev;
    logic [3:0] k;
    logic [7:0] b;
    logic [1:0] j;
    ev = '0;
    k  = '0;
    b  = '0;
    j  = '0;
    ev.hold_ms = HOLD_SHORT;
    if (d.is_init) begin
      if (idx == 4'd0) begin
        ev.hold_ms = HOLD_LONG;
      end else if (idx inside {[4'd1:4'd6]}) begin
        k = idx - 4'd1;
        ev.nibble = (k[2:1] == 2'd2) ? NIB_4BIT : NIB_WAKE;
        ev.enable = ~k[0];
      end else begin
        k = idx - 4'd7;
        b = k[2] ? CMD_DISPLAY_ON : CMD_FUNCTION_SET;
        j = k[1:0];
        ev.nibble = j[1] ? b[3:0] : b[7:4];
        ev.enable = ~j[0];
      end
      ev.last = (idx == INIT_LAST_IDX);
    end else begin
      j = idx[1:0];
      ev.nibble     = j[1] ? d.byte_val[3:0] : d.byte_val[7:4];
      ev.enable     = ~j[0];
      ev.reg_select = d.rs & ~j[0];
      ev.last       = (j == 2'd3);
    end
    return ev;
  endfunction

endpackage

@@ rtl/char_lcd_nibble_write_sequencer.sv @@
// Character LCD 4-bit write sequencer.
// Requests enter through a queue-style port: action, byte_value, column and
// row are taken at an edge with push high and full low. Each request becomes
// a run of pin events (nibble, reg_select, enable, hold_ms, last) presented
// queue-style: the oldest event is on the outputs while empty is low and is
// taken at an edge with pop high. last marks the final event of a run.
// Init yields 15 events; command, character and goto yield 4 events each.
// An accepted request moves from the queue into the sequencer, and its first
// event is then registered onto the outputs. The sequencer emits one event per
// cycle unless pop stalls it, and loads the next queued request as it emits
// the last event of a run. A small request queue between the front end and
// the sequencer lets new requests be accepted while events are still
// draining; full rises when it holds QueueDepth requests. When pop stays
// low, the current event holds on the outputs and the sequencer waits. Line
// base registers are written through cfg_we_i/cfg_idx_i/cfg_data_i while
// idle, which the user must keep to; the block does not enforce it. Reset
// empties both sides and restores the line bases to 0, 64, 20 and 84.
module char_lcd_nibble_write_sequencer #(
  parameter int QueueDepth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [6:0] cfg_data_i,
  input  logic       push,
  output logic       full,
  input  logic [1:0] action_i,
  input  logic [7:0] byte_value_i,
  input  logic [7:0] column_i,
  input  logic [7:0] row_i,
  output logic       empty,
  input  logic       pop,
  output logic [3:0] nibble_o,
  output logic       reg_select_o,
  output logic       enable_o,
  output logic [3:0] hold_ms_o,
  output logic       last_o
);

  clnws_pkg::desc_t  front_desc, q_desc;
  clnws_pkg::event_t ev;
  logic              q_empty, q_rd;

  clnws_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .action_i     (action_i),
    .byte_value_i (byte_value_i),
    .column_i     (column_i),
    .row_i        (row_i),
    .desc_o       (front_desc)
  );

  clnws_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (push),
    .wdata_i (front_desc),
    .full_o  (full),
    .rd_i    (q_rd),
    .rdata_o (q_desc),
    .empty_o (q_empty)
  );

  clnws_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_desc_i  (q_desc),
    .q_rd_o    (q_rd),
    .empty     (empty),
    .pop       (pop),
    .event_o   (ev)
  );

  assign nibble_o     = ev.nibble;
  assign reg_select_o = ev.reg_select;
  assign enable_o     = ev.enable;
  assign hold_ms_o    = ev.hold_ms;
  assign last_o       = ev.last;

endmodule

@@ rtl/clnws_front.sv @@
module clnws_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [6:0]         cfg_data_i,
  input  logic [1:0]         action_i,
  input  logic [7:0]         byte_value_i,
  input  logic [7:0]         column_i,
  input  logic [7:0]         row_i,
  output clnws_pkg::desc_t   desc_o
);

  logic [6:0] base_q [4];
  logic [6:0] base;
  logic [6:0] addr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q[0] <= clnws_pkg::LINE0_RESET;
      base_q[1] <= clnws_pkg::LINE1_RESET;
      base_q[2] <= clnws_pkg::LINE2_RESET;
      base_q[3] <= clnws_pkg::LINE3_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        clnws_pkg::REG_LINE0_BASE: base_q[0] <= cfg_data_i;
        clnws_pkg::REG_LINE1_BASE: base_q[1] <= cfg_data_i;
        clnws_pkg::REG_LINE2_BASE: base_q[2] <= cfg_data_i;
        clnws_pkg::REG_LINE3_BASE: base_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Rows above three fall back to row 0.
  assign base = (row_i > 8'd3) ? base_q[0] : base_q[row_i[1:0]];
  assign addr = base + column_i[6:0];

  always_comb begin
    desc_o = '0;
    case (clnws_pkg::action_e'(action_i))
      clnws_pkg::ACT_INIT: desc_o.is_init = 1'b1;
      clnws_pkg::ACT_CMD:  desc_o.byte_val = byte_value_i;
      clnws_pkg::ACT_CHAR: begin
        desc_o.byte_val = byte_value_i;
        desc_o.rs       = 1'b1;
      end
      clnws_pkg::ACT_GOTO: desc_o.byte_val = clnws_pkg::CMD_SET_ADDRESS | {1'b0, addr};
      default: ;
    endcase
  end

endmodule

@@ rtl/clnws_queue.sv @@
module clnws_queue #(
  parameter int Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  clnws_pkg::desc_t wdata_i,
  output logic             full_o,
  input  logic             rd_i,
  output clnws_pkg::desc_t rdata_o,
  output logic             empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  clnws_pkg::desc_t mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_wr, do_rd;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_wr   = wr_i & ~full_o;
  assign do_rd   = rd_i & ~empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

@@ rtl/clnws_back.sv @@
module clnws_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_empty_i,
  input  clnws_pkg::desc_t  q_desc_i,
  output logic              q_rd_o,
  output logic              empty,
  input  logic              pop,
  output clnws_pkg::event_t event_o
);

  clnws_pkg::desc_t  desc_q, desc_d;
  clnws_pkg::event_t ev, out_q, out_d;
  logic [3:0]        idx_q, idx_d;
  logic              active_q, active_d;
  logic              out_valid_q, out_valid_d;
  logic              adv, emit, done, load;

  assign ev    = clnws_pkg::lcd_event(desc_q, idx_q);
  assign adv   = ~out_valid_q | pop;
  assign emit  = active_q & adv;
  assign done  = emit & ev.last;
  assign load  = ~q_empty_i & (~active_q | done);

  assign q_rd_o  = load;
  assign empty   = ~out_valid_q;
  assign event_o = out_q;

  always_comb begin
    desc_d      = desc_q;
    idx_d       = idx_q;
    active_d    = active_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (adv) begin
      out_valid_d = emit;
      out_d       = ev;
    end
    if (emit) begin
      idx_d = idx_q + 4'd1;
    end
    if (done) begin
      active_d = 1'b0;
    end
    if (load) begin
      desc_d   = q_desc_i;
      idx_d    = '0;
      active_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    desc_q <= desc_d;
    out_q  <= out_d;
  end

endmodule

@@ rtl/clnws_checker.sv @@
`include "assert_macros.svh"

module clnws_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       empty,
  input logic       pop,
  input logic [3:0] nibble_o,
  input logic       reg_select_o,
  input logic       enable_o,
  input logic [3:0] hold_ms_o,
  input logic       last_o
);

  logic        stalled;
  logic [10:0] evt_bits;
  logic        idle_ok;
  assign stalled  = ~empty & ~pop;
  assign evt_bits = {nibble_o, reg_select_o, enable_o, hold_ms_o, last_o};
  assign idle_ok  = (hold_ms_o == 4'd15) && (nibble_o == 4'd0) && !enable_o && !reg_select_o;

  `ASSERT_NEXT(a_stall_hold, clk_i, rst_ni, stalled, !empty && $stable(evt_bits))
  `ASSERT_IMPL(a_last_low, clk_i, rst_ni, !empty && last_o, !enable_o)
  `ASSERT_IMPL(a_strobe_short, clk_i, rst_ni, !empty && enable_o, hold_ms_o == 4'd1)
  `ASSERT_IMPL(a_idle_pins, clk_i, rst_ni, !empty && hold_ms_o != 4'd1, idle_ok)
  `ASSERT_IMPL(a_rs_with_en, clk_i, rst_ni, !empty && reg_select_o, enable_o)

endmodule

bind char_lcd_nibble_write_sequencer clnws_checker u_clnws_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .empty        (empty),
  .pop          (pop),
  .nibble_o     (nibble_o),
  .reg_select_o (reg_select_o),
  .enable_o     (enable_o),
  .hold_ms_o    (hold_ms_o),
  .last_o       (last_o)
);

@@ tb/lcd_pin_event_scoreboard.sv @@
module lcd_pin_event_scoreboard
  import clnws_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [6:0] cfg_data_i,
  input  logic       push_i,
  input  logic       full_i,
  input  logic [1:0] action_i,
  input  logic [7:0] byte_value_i,
  input  logic [7:0] column_i,
  input  logic [7:0] row_i,
  input  logic       empty_i,
  input  logic       pop_i,
  input  logic [3:0] nibble_i,
  input  logic       reg_select_i,
  input  logic       enable_i,
  input  logic [3:0] hold_ms_i,
  input  logic       last_i,
  output int         fail_count_o,
  output int         outstanding_o
);

  logic [6:0] line_base [4];
  event_t     pin_events [$];
  event_t     run_events [$];
  event_t     want;
  int         mismatches = 0;
  int         events_seen = 0;

  task automatic report(input string msg);
    $display("event %0d: %s", events_seen, msg);
    mismatches++;
  endtask

  function automatic void add_event(input logic [3:0] nib, input logic rs, input logic en,
                                    input logic [3:0] hold);
    event_t ev;
    ev.nibble     = nib;
    ev.reg_select = rs;
    ev.enable     = en;
    ev.hold_ms    = hold;
    ev.last       = 1'b0;
    run_events.push_back(ev);
  endfunction

  function automatic void add_strobe(input logic [3:0] nib, input logic rs);
    add_event(nib, rs, 1'b1, HOLD_SHORT);
    add_event(nib, 1'b0, 1'b0, HOLD_SHORT);
  endfunction

  function automatic void add_byte(input logic [7:0] b, input logic rs);
    add_strobe(b[7:4], rs);
    add_strobe(b[3:0], rs);
  endfunction

  function automatic void predict_pin_run(input logic [1:0] act, input logic [7:0] b,
                                          input logic [7:0] col, input logic [7:0] row);
    logic [6:0] base;
    logic [6:0] addr;
    run_events.delete();
    case (action_e'(act))
      ACT_INIT: begin
        add_event(4'h0, 1'b0, 1'b0, HOLD_LONG);
        add_strobe(NIB_WAKE, 1'b0);
        add_strobe(NIB_WAKE, 1'b0);
        add_strobe(NIB_4BIT, 1'b0);
        add_byte(CMD_FUNCTION_SET, 1'b0);
        add_byte(CMD_DISPLAY_ON, 1'b0);
      end
      ACT_CMD:  add_byte(b, 1'b0);
      ACT_CHAR: add_byte(b, 1'b1);
      default: begin
        base = (row <= 8'd3) ? line_base[row[1:0]] : line_base[REG_LINE0_BASE];
        addr = base + col[6:0];
        add_byte(CMD_SET_ADDRESS | {1'b0, addr}, 1'b0);
      end
    endcase
    run_events[run_events.size() - 1].last = 1'b1;
    foreach (run_events[i]) pin_events.push_back(run_events[i]);
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      line_base[REG_LINE0_BASE] <= LINE0_RESET;
      line_base[REG_LINE1_BASE] <= LINE1_RESET;
      line_base[REG_LINE2_BASE] <= LINE2_RESET;
      line_base[REG_LINE3_BASE] <= LINE3_RESET;
      pin_events.delete();
    end else begin
      if (pop_i && !empty_i) begin
        if (pin_events.size() == 0) begin
          report($sformatf("unexpected event nibble %h rs %b en %b hold %0d last %b",
                           nibble_i, reg_select_i, enable_i, hold_ms_i, last_i));
        end else begin
          want = pin_events.pop_front();
          if (nibble_i !== want.nibble)
            report($sformatf("nibble got %h want %h", nibble_i, want.nibble));
          if (reg_select_i !== want.reg_select)
            report($sformatf("reg_select got %b want %b", reg_select_i, want.reg_select));
          if (enable_i !== want.enable)
            report($sformatf("enable got %b want %b", enable_i, want.enable));
          if (hold_ms_i !== want.hold_ms)
            report($sformatf("hold_ms got %0d want %0d", hold_ms_i, want.hold_ms));
          if (last_i !== want.last)
            report($sformatf("last got %b want %b", last_i, want.last));
        end
        events_seen++;
      end
      if (push_i && !full_i) predict_pin_run(action_i, byte_value_i, column_i, row_i);
      if (cfg_we_i) line_base[cfg_idx_i] <= cfg_data_i;
    end
    outstanding_o <= pin_events.size();
    fail_count_o  <= mismatches;
  end

endmodule

@@ tb/char_lcd_nibble_write_sequencer_test.sv @@
module char_lcd_nibble_write_sequencer_test;
  import clnws_pkg::*;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_idx = REG_LINE0_BASE;
  logic [6:0] cfg_data = 7'd0;
  logic       push = 1'b0;
  logic       full;
  logic [1:0] action = ACT_INIT;
  logic [7:0] byte_value = 8'd0;
  logic [7:0] column = 8'd0;
  logic [7:0] row = 8'd0;
  logic       empty;
  logic       pop = 1'b0;
  logic [3:0] nibble;
  logic       reg_select;
  logic       enable;
  logic [3:0] hold_ms;
  logic       last;
  int         fail_count;
  int         outstanding;
  bit         send_calm = 1'b0;
  bit         take_calm = 1'b0;

  char_lcd_nibble_write_sequencer uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .push         (push),
    .full         (full),
    .action_i     (action),
    .byte_value_i (byte_value),
    .column_i     (column),
    .row_i        (row),
    .empty        (empty),
    .pop          (pop),
    .nibble_o     (nibble),
    .reg_select_o (reg_select),
    .enable_o     (enable),
    .hold_ms_o    (hold_ms),
    .last_o       (last)
  );

  lcd_pin_event_scoreboard u_scoreboard (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .push_i        (push),
    .full_i        (full),
    .action_i      (action),
    .byte_value_i  (byte_value),
    .column_i      (column),
    .row_i         (row),
    .empty_i       (empty),
    .pop_i         (pop),
    .nibble_i      (nibble),
    .reg_select_i  (reg_select),
    .enable_i      (enable),
    .hold_ms_i     (hold_ms),
    .last_i        (last),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #4000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // drain side: random stalls, with calm stretches
  initial begin
    int gap;
    forever begin
      if ($urandom_range(0, 31) == 0) take_calm = ~take_calm;
      gap = take_calm ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
    end
  end

  task automatic send_request(input action_e act, input logic [7:0] b,
                              input logic [7:0] col, input logic [7:0] r);
    int gap;
    if ($urandom_range(0, 31) == 0) send_calm = ~send_calm;
    gap = send_calm ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push       <= 1'b1;
    action     <= act;
    byte_value <= b;
    column     <= col;
    row        <= r;
    do @(posedge clk_i); while (full);
  endtask

  task automatic send_random_request();
    logic [7:0] r;
    r = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(4, 255)) : 8'($urandom_range(0, 3));
    send_request(action_e'($urandom_range(0, 3)), 8'($urandom), 8'($urandom), r);
  endtask

  // hold off until every pin event has been taken
  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic drive_cfg(input logic [1:0] idx, input logic [6:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk_i);
  endtask

  task automatic load_line_bases(input logic [6:0] b0, input logic [6:0] b1,
                                 input logic [6:0] b2, input logic [6:0] b3);
    wait_drained();
    drive_cfg(REG_LINE0_BASE, b0);
    drive_cfg(REG_LINE1_BASE, b1);
    drive_cfg(REG_LINE2_BASE, b2);
    drive_cfg(REG_LINE3_BASE, b3);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [6:0] pick_base();
    case ($urandom_range(0, 3))
      0:       return 7'd0;
      1:       return 7'd127;
      default: return 7'($urandom);
    endcase
  endfunction

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_request(ACT_INIT, 8'hFF, 8'hFF, 8'hFF);
    send_request(ACT_CMD, 8'h00, 8'h00, 8'h00);
    send_request(ACT_CMD, 8'hFF, 8'hAA, 8'h55);
    send_request(ACT_CHAR, 8'h00, 8'h00, 8'h00);
    send_request(ACT_CHAR, 8'hFF, 8'hFF, 8'hFF);
    send_request(ACT_CHAR, 8'h5A, 8'h12, 8'h02);
    send_request(ACT_CMD, 8'hA5, 8'h00, 8'h00);
    send_request(ACT_GOTO, 8'h00, 8'd0, 8'd0);
    send_request(ACT_GOTO, 8'hFF, 8'd0, 8'd1);
    send_request(ACT_GOTO, 8'h00, 8'd255, 8'd2);
    send_request(ACT_GOTO, 8'h00, 8'd127, 8'd3);
    send_request(ACT_GOTO, 8'h00, 8'd5, 8'd4);
    send_request(ACT_GOTO, 8'hFF, 8'd200, 8'd255);

    load_line_bases(7'd127, 7'd127, 7'd127, 7'd127);
    for (int r = 0; r <= 3; r++) send_request(ACT_GOTO, 8'h00, 8'd1, 8'(r));
    send_request(ACT_GOTO, 8'h00, 8'd0, 8'd200);

    load_line_bases(7'd0, 7'd0, 7'd0, 7'd0);
    send_request(ACT_GOTO, 8'h00, 8'd255, 8'd3);
    send_request(ACT_INIT, 8'h00, 8'h00, 8'h00);

    for (int phase = 0; phase < 5; phase++) begin
      load_line_bases(pick_base(), pick_base(), pick_base(), pick_base());
      for (int n = 0; n < 90; n++) begin
        if (n == 45) wait_drained();
        send_random_request();
      end
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
